@@ src/tmp_pkg.sv @@
package tmp_pkg;

    // Internal working width of every magnitude, matching the saturating 64-bit datapath.
    localparam int DW = 64;

    // Latencies of the arithmetic units.
    localparam int MUL_LAT  = 2;
    localparam int DIV_LAT  = DW;
    localparam int SQRT_LAT = DW / 2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_VELOCITY = 2'd0;
    localparam logic [1:0] CFG_ACCELERATION = 2'd1;

    typedef logic [DW-1:0] t_word;

    // One request as it travels down the pipeline; fields fill in stage by stage.
    typedef struct packed {
        t_word s;
        t_word g;
        t_word t;
        t_word span;
        t_word v;
        t_word a;
        t_word ta0;
        t_word vp_tri;
        t_word s2;
        t_word tc;
        t_word ta_tri;
        t_word vp;
        t_word ta;
        t_word t2;
        t_word t3;
        t_word x;
        t_word y;
        t_word m_ata;
        t_word m_ax;
        t_word lin;
        t_word vc;
        t_word h;
        t_word q;
        t_word hv;
        t_word rr;
        t_word l2;
        t_word p;
        logic  neg;
        logic  ph1;
        logic  ph2;
        logic  done;
    } t_item;

    // Unsigned add that clamps at all ones.
    function automatic t_word add_sat(t_word x, t_word y);
        logic [DW:0] r;
        r = {1'b0, x} + {1'b0, y};
        return r[DW] ? '1 : r[DW-1:0];
    endfunction

endpackage

@@ src/tmp_mul.sv @@
module tmp_mul (
    input  logic          i_clk,
    input  logic          i_en,
    input  tmp_pkg::t_word i_a,
    input  tmp_pkg::t_word i_b,
    output tmp_pkg::t_word o_prod
);
    import tmp_pkg::*;

    localparam int H = DW / 2;

    logic [H-1:0] w_al, w_ah, w_bl, w_bh;
    t_word r_ll, r_lh, r_hl, r_hh;
    t_word r_prod;
    logic [DW:0]     w_mid;
    logic [2*DW-1:0] w_full;

    assign w_al = i_a[H-1:0];
    assign w_ah = i_a[DW-1:H];
    assign w_bl = i_b[H-1:0];
    assign w_bh = i_b[DW-1:H];

    // First stage: four half-width partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= w_al * w_bl;
            r_lh <= w_al * w_bh;
            r_hl <= w_ah * w_bl;
            r_hh <= w_ah * w_bh;
        end
    end

    // Second stage: combine the partial products and clamp on overflow.
    assign w_mid  = {1'b0, r_lh} + {1'b0, r_hl};
    assign w_full = {r_hh, {DW{1'b0}}}
                  + {{(DW-H-1){1'b0}}, w_mid, {H{1'b0}}}
                  + {{DW{1'b0}}, r_ll};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= (w_full[2*DW-1:DW] != '0) ? '1 : w_full[DW-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

@@ src/tmp_div.sv @@
module tmp_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  tmp_pkg::t_word i_num,
    input  tmp_pkg::t_word i_den,
    output tmp_pkg::t_word o_quo
);
    import tmp_pkg::*;

    t_word r_num [DW];
    t_word r_den [DW];
    t_word r_rem [DW];
    t_word r_quo [DW];

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < DW; k++) begin : g_stage
        t_word       p_num, p_den, p_rem, p_quo;
        logic [DW:0] w_sh;
        logic        w_fit;

        if (k == 0) begin : g_first
            assign p_num = i_num;
            assign p_den = i_den;
            assign p_rem = '0;
            assign p_quo = '0;
        end else begin : g_next
            assign p_num = r_num[k-1];
            assign p_den = r_den[k-1];
            assign p_rem = r_rem[k-1];
            assign p_quo = r_quo[k-1];
        end

        assign w_sh  = {p_rem, p_num[DW-1]};
        assign w_fit = (w_sh >= {1'b0, p_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= p_num << 1;
                r_den[k] <= p_den;
                r_rem[k] <= w_fit ? DW'(w_sh - {1'b0, p_den}) : w_sh[DW-1:0];
                r_quo[k] <= {p_quo[DW-2:0], w_fit};
            end
        end
    end

    assign o_quo = r_quo[DW-1];

endmodule

@@ src/tmp_sqrt.sv @@
module tmp_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  tmp_pkg::t_word                i_rad,
    output logic [tmp_pkg::DW/2-1:0]      o_root
);
    import tmp_pkg::*;

    localparam int N  = DW / 2;
    localparam int RW = N + 2;

    t_word          r_rad  [N];
    logic [RW-1:0]  r_rem  [N];
    logic [N-1:0]   r_root [N];

    // Digit-by-digit integer square root, two radicand bits per stage.
    for (genvar k = 0; k < N; k++) begin : g_stage
        t_word         p_rad;
        logic [RW-1:0] p_rem;
        logic [N-1:0]  p_root;
        logic [RW+1:0] w_sh;
        logic [RW+1:0] w_trial;
        logic          w_fit;

        if (k == 0) begin : g_first
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
        end else begin : g_next
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
        end

        assign w_sh    = {p_rem, p_rad[DW-1:DW-2]};
        assign w_trial = {2'b00, p_root, 2'b01};
        assign w_fit   = (w_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= p_rad << 2;
                r_rem[k]  <= w_fit ? RW'(w_sh - w_trial) : w_sh[RW-1:0];
                r_root[k] <= {p_root[N-2:0], w_fit};
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule

@@ src/tmp_dly.sv @@
module tmp_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    // Payload delay line that advances with the pipeline.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

@@ src/trapezoidal_motion_profile.sv @@
// Pipeline from an accepted request to its result: input stage, two 64-stage dividers
// in series with multipliers between them, phase and output stages.
// Throughput: one request per cycle; the whole pipeline holds while the output is stalled.
// Reset (synchronous, active low) clears the valid bits and sets both registers to 1.0.
// The configuration is sampled with each request, so requests in flight keep their values.
module trapezoidal_motion_profile #(
    parameter int FRACTION_BITS = 16,
    parameter int VALUE_WIDTH   = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_start_position,
    input  logic signed [VALUE_WIDTH-1:0] i_target_position,
    input  logic        [VALUE_WIDTH-1:0] i_elapsed_time,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_WIDTH-1:0] o_position,
    output logic                          o_arrived,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic        [1:0]             i_cfg_index,
    input  logic        [VALUE_WIDTH-1:0] i_cfg_data
);
    import tmp_pkg::*;

    localparam int W   = VALUE_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int LAT = 1 + DIV_LAT + MUL_LAT + DIV_LAT + 3 + MUL_LAT + MUL_LAT + 3;
    localparam int IW  = $bits(t_item);

    localparam logic [W-2:0] CFG_RESET = (W-1)'(64'd1 << F);
    localparam t_word        P_CAP     = t_word'(64'd1 << (W + 1));
    localparam logic signed [DW+1:0] POS_MAX =
        signed'((DW+2)'((64'd1 << (W - 1)) - 64'd1));
    localparam logic signed [DW+1:0] POS_MIN = -POS_MAX - 1;

    // Saturating shift left by the fraction width.
    function automatic t_word shl_sat(t_word x);
        return ((x >> (DW - F)) != '0) ? '1 : (x << F);
    endfunction

    logic [W-2:0]   r_max_velocity, r_acceleration;
    logic [LAT-1:0] r_vld;
    logic           w_en;

    t_item n_s0, r_s0;
    t_item w_a_raw, w_a, w_b_raw, w_b, w_c_raw, w_c;
    t_item n_c1, r_c1, n_c2, r_c2, n_c3, r_c3;
    t_item w_d_raw, w_d, w_e_raw, w_e;
    t_item n_f1, r_f1, n_f2, r_f2;

    t_word w_ta0, w_da, w_s2p, w_num_tc, w_tc, w_tat;
    t_word w_p_ata, w_p_ax, w_p_lin, w_p_vc, w_p_h, w_p_q;
    logic [DW/2-1:0] w_root, w_root_d;

    logic signed [DW:0]   w_diff;
    logic signed [DW+1:0] w_sx, w_px, w_sum;
    logic signed [W-1:0]  r_pos;
    logic                 r_arrived;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_velocity <= CFG_RESET;
            r_acceleration <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_VELOCITY: r_max_velocity <= i_cfg_data[W-2:0];
                CFG_ACCELERATION: r_acceleration <= i_cfg_data[W-2:0];
                default: begin
                end
            endcase
        end
    end

    // Global pipeline advance and valid bits.
    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Input stage: widen the fields, take the distance and sample the registers.
    always_comb begin
        n_s0      = '0;
        n_s0.s    = {{(DW-W){i_start_position[W-1]}}, i_start_position};
        n_s0.g    = {{(DW-W){i_target_position[W-1]}}, i_target_position};
        n_s0.t    = {{(DW-W){1'b0}}, i_elapsed_time};
        w_diff    = signed'({n_s0.g[DW-1], n_s0.g}) - signed'({n_s0.s[DW-1], n_s0.s});
        n_s0.neg  = w_diff[DW] || (w_diff == '0);
        n_s0.span = n_s0.neg ? DW'(-w_diff) : w_diff[DW-1:0];
        n_s0.v    = (r_max_velocity == '0) ? t_word'(1) : {{(DW-W+1){1'b0}}, r_max_velocity};
        n_s0.a    = (r_acceleration == '0) ? t_word'(1) : {{(DW-W+1){1'b0}}, r_acceleration};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= n_s0;
        end
    end

    // Acceleration time at peak velocity, in parallel with the triangular peak velocity.
    tmp_div u_div_ta0 (
        .i_clk(i_clk), .i_en(w_en), .i_num(shl_sat(r_s0.v)), .i_den(r_s0.a), .o_quo(w_ta0)
    );

    tmp_mul u_mul_da (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_s0.span), .i_b(r_s0.a), .o_prod(w_da)
    );

    tmp_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(w_en), .i_rad(w_da), .o_root(w_root)
    );

    tmp_dly #(.WIDTH(DW/2), .DEPTH(DIV_LAT - MUL_LAT - SQRT_LAT)) u_dly_root (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_root), .o_q(w_root_d)
    );

    tmp_dly #(.WIDTH(IW), .DEPTH(DIV_LAT)) u_dly_a (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_s0), .o_q(w_a_raw)
    );

    always_comb begin
        w_a        = w_a_raw;
        w_a.ta0    = w_ta0;
        w_a.vp_tri = {{(DW/2){1'b0}}, w_root_d};
    end

    // Distance covered by the acceleration and deceleration ramps.
    tmp_mul u_mul_s2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_a.v), .i_b(w_a.ta0), .o_prod(w_s2p)
    );

    tmp_dly #(.WIDTH(IW), .DEPTH(MUL_LAT)) u_dly_b (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_a), .o_q(w_b_raw)
    );

    always_comb begin
        w_b    = w_b_raw;
        w_b.s2 = w_s2p >> F;
    end

    // Cruise time and triangular acceleration time, side by side.
    assign w_num_tc = (w_b.span > w_b.s2) ? shl_sat(w_b.span - w_b.s2) : '0;

    tmp_div u_div_tc (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_num_tc), .i_den(w_b.v), .o_quo(w_tc)
    );

    tmp_div u_div_tat (
        .i_clk(i_clk), .i_en(w_en), .i_num(shl_sat(w_b.vp_tri)), .i_den(w_b.a), .o_quo(w_tat)
    );

    tmp_dly #(.WIDTH(IW), .DEPTH(DIV_LAT)) u_dly_c (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_b), .o_q(w_c_raw)
    );

    always_comb begin
        w_c        = w_c_raw;
        w_c.tc     = w_tc;
        w_c.ta_tri = w_tat;
    end

    // Pick trapezoid or triangle and form the end of cruise.
    always_comb begin
        n_c1    = w_c;
        n_c1.vp = (w_c.tc == '0) ? w_c.vp_tri : w_c.v;
        n_c1.ta = (w_c.tc == '0) ? w_c.ta_tri : w_c.ta0;
        n_c1.t2 = add_sat(n_c1.ta, w_c.tc);
    end

    // End of move and phase compares.
    always_comb begin
        n_c2     = r_c1;
        n_c2.t3  = add_sat(r_c1.t2, r_c1.ta);
        n_c2.ph1 = (r_c1.t <= r_c1.ta);
        n_c2.ph2 = (r_c1.t <= r_c1.t2);
    end

    // Time offsets into the current phase.
    always_comb begin
        n_c3      = r_c2;
        n_c3.done = (r_c2.t > r_c2.t3);
        if (r_c2.ph1) begin
            n_c3.x = r_c2.t;
            n_c3.y = '0;
        end else if (r_c2.ph2) begin
            n_c3.x = '0;
            n_c3.y = r_c2.t - r_c2.ta;
        end else begin
            n_c3.x = r_c2.t - r_c2.t2;
            n_c3.y = r_c2.t - r_c2.t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1 <= n_c1;
            r_c2 <= n_c2;
            r_c3 <= n_c3;
        end
    end

    // First products: a*ta, a*x, vp*y and vp*tc.
    tmp_mul u_mul_ata (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_c3.a), .i_b(r_c3.ta), .o_prod(w_p_ata)
    );

    tmp_mul u_mul_ax (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_c3.a), .i_b(r_c3.x), .o_prod(w_p_ax)
    );

    tmp_mul u_mul_lin (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_c3.vp), .i_b(r_c3.y), .o_prod(w_p_lin)
    );

    tmp_mul u_mul_vc (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_c3.vp), .i_b(r_c3.tc), .o_prod(w_p_vc)
    );

    tmp_dly #(.WIDTH(IW), .DEPTH(MUL_LAT)) u_dly_d (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_c3), .o_q(w_d_raw)
    );

    always_comb begin
        w_d       = w_d_raw;
        w_d.m_ata = w_p_ata >> F;
        w_d.m_ax  = w_p_ax >> F;
        w_d.lin   = w_p_lin >> F;
        w_d.vc    = w_p_vc >> F;
    end

    // Second products give the half-square terms.
    tmp_mul u_mul_h (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_d.m_ata), .i_b(w_d.ta), .o_prod(w_p_h)
    );

    tmp_mul u_mul_q (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_d.m_ax), .i_b(w_d.x), .o_prod(w_p_q)
    );

    tmp_dly #(.WIDTH(IW), .DEPTH(MUL_LAT)) u_dly_e (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_d), .o_q(w_e_raw)
    );

    always_comb begin
        w_e   = w_e_raw;
        w_e.h = (w_p_h >> F) >> 1;
        w_e.q = (w_p_q >> F) >> 1;
    end

    // Partial sums for the cruise and deceleration phases.
    always_comb begin
        n_f1    = w_e;
        n_f1.hv = add_sat(w_e.h, w_e.vc);
        n_f1.rr = (w_e.lin > w_e.q) ? (w_e.lin - w_e.q) : '0;
        n_f1.l2 = add_sat(w_e.h, w_e.lin);
    end

    // Travel along the profile for the active phase, capped.
    always_comb begin
        n_f2 = r_f1;
        if (r_f1.ph1) begin
            n_f2.p = r_f1.q;
        end else if (r_f1.ph2) begin
            n_f2.p = r_f1.l2;
        end else begin
            n_f2.p = add_sat(r_f1.hv, r_f1.rr);
        end
        if (n_f2.p > P_CAP) begin
            n_f2.p = P_CAP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
        end
    end

    // Apply the direction, saturate, or hold at the target once the move is over.
    assign w_sx  = signed'({{2{r_f2.s[DW-1]}}, r_f2.s});
    assign w_px  = signed'({2'b00, r_f2.p});
    assign w_sum = r_f2.neg ? (w_sx - w_px) : (w_sx + w_px);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_arrived <= r_f2.done;
            if (r_f2.done) begin
                r_pos <= r_f2.g[W-1:0];
            end else if (w_sum > POS_MAX) begin
                r_pos <= POS_MAX[W-1:0];
            end else if (w_sum < POS_MIN) begin
                r_pos <= POS_MIN[W-1:0];
            end else begin
                r_pos <= w_sum[W-1:0];
            end
        end
    end

    assign o_position = r_pos;
    assign o_arrived  = r_arrived;

endmodule

@@ bench/motion_profile_checker.sv @@
`timescale 1ns / 1ps

// Watches the request, result and register channels of the profile block, computes
// the commanded position of every accepted request and compares it with the results.
module motion_profile_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic signed [31:0] i_start_position,
    input  logic signed [31:0] i_target_position,
    input  logic        [31:0] i_elapsed_time,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_position,
    input  logic               o_arrived,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [31:0] i_cfg_data,
    output int                 o_pending,
    output int                 o_failures
);
    import tmp_pkg::*;

    localparam int FRAC = 16;
    localparam logic [63:0] ALL_ONES = '1;
    localparam longint POS_HI = 64'sd2147483647;
    localparam longint POS_LO = -64'sd2147483648;

    typedef struct {
        logic [31:0] position;
        logic        arrived;
    } t_setpoint;

    t_setpoint   setpoint_q[$];
    logic [63:0] peak_velocity;
    logic [63:0] accel_rate;

    // Saturating 64-bit helpers.
    function automatic logic [63:0] mul_clamp(logic [63:0] x, logic [63:0] y);
        logic [127:0] prod;
        prod = x * y;
        return (prod[127:64] != 0) ? ALL_ONES : prod[63:0];
    endfunction

    function automatic logic [63:0] add_clamp(logic [63:0] x, logic [63:0] y);
        logic [64:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        return sum[64] ? ALL_ONES : sum[63:0];
    endfunction

    function automatic logic [63:0] shift_clamp(logic [63:0] x);
        return (x > (ALL_ONES >> FRAC)) ? ALL_ONES : (x << FRAC);
    endfunction

    function automatic logic [63:0] qmul(logic [63:0] x, logic [63:0] y);
        return mul_clamp(x, y) >> FRAC;
    endfunction

    function automatic logic [63:0] half_square(logic [63:0] acc, logic [63:0] t);
        return qmul(qmul(acc, t), t) >> 1;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Commanded position on the trapezoidal (or triangular) profile at time t.
    function automatic t_setpoint profile_point(logic signed [31:0] s_pos,
                                                logic signed [31:0] g_pos,
                                                logic [31:0] t_raw,
                                                logic [63:0] vreg, logic [63:0] areg);
        t_setpoint   r;
        longint      d;
        longint      pos;
        logic        neg;
        logic [63:0] span, v, a, ta, s2, tc, vp, t2, t3, h, p, t, u, lin, q;
        d = longint'(g_pos) - longint'(s_pos);
        neg = (d <= 0);
        span = neg ? -d : d;
        t = {32'd0, t_raw};
        v = (vreg != 0) ? vreg : 64'd1;
        a = (areg != 0) ? areg : 64'd1;
        ta = shift_clamp(v) / a;
        s2 = qmul(v, ta);
        tc = 0;
        vp = v;
        if (span > s2) tc = shift_clamp(span - s2) / v;
        // No cruise phase: the peak velocity is what the distance allows.
        if (tc == 0) begin
            vp = int_sqrt(mul_clamp(span, a));
            ta = shift_clamp(vp) / a;
        end
        t2 = add_clamp(ta, tc);
        t3 = add_clamp(t2, ta);
        h = half_square(a, ta);
        if (t > t3) begin
            r.position = g_pos;
            r.arrived = 1'b1;
            return r;
        end
        if (t <= ta) begin
            p = half_square(a, t);
        end else if (t <= t2) begin
            p = add_clamp(h, qmul(vp, t - ta));
        end else begin
            u = t - t2;
            lin = qmul(vp, u);
            q = half_square(a, u);
            p = add_clamp(add_clamp(h, qmul(vp, tc)), (lin > q) ? lin - q : 64'd0);
        end
        if (p > (64'd1 << 33)) p = 64'd1 << 33;
        pos = neg ? longint'(s_pos) - longint'(p) : longint'(s_pos) + longint'(p);
        if (pos > POS_HI) pos = POS_HI;
        if (pos < POS_LO) pos = POS_LO;
        r.position = pos[31:0];
        r.arrived = 1'b0;
        return r;
    endfunction

    assign o_pending = setpoint_q.size();

    // Track the registers, queue a prediction per request and compare each result.
    always @(posedge i_clk) begin
        t_setpoint exp_pt;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            peak_velocity = 64'd65536;
            accel_rate = 64'd65536;
            setpoint_q.delete();
            o_failures <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MAX_VELOCITY) peak_velocity = {33'd0, i_cfg_data[30:0]};
                if (i_cfg_index == CFG_ACCELERATION) accel_rate = {33'd0, i_cfg_data[30:0]};
            end
            if (i_valid && !o_stall) begin
                setpoint_q.push_back(profile_point(i_start_position, i_target_position,
                                                   i_elapsed_time, peak_velocity, accel_rate));
            end
            if (o_valid && !i_stall) begin
                if (setpoint_q.size() == 0) begin
                    $error("unexpected result: position %0d arrived %0d", o_position, o_arrived);
                    errs = errs + 1;
                end else begin
                    exp_pt = setpoint_q.pop_front();
                    if (o_position !== exp_pt.position) begin
                        $error("position: expected %0d, actual %0d",
                               $signed(exp_pt.position), o_position);
                        errs = errs + 1;
                    end
                    if (o_arrived !== exp_pt.arrived) begin
                        $error("arrived: expected %0d, actual %0d", exp_pt.arrived, o_arrived);
                        errs = errs + 1;
                    end
                end
            end
            if (errs != 0) begin
                o_failures <= o_failures + errs;
            end
        end
    end
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import tmp_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd2;
    localparam int DRAIN_CYCLES = 200;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_start_position;
    logic signed [31:0] i_target_position;
    logic        [31:0] i_elapsed_time;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_position;
    logic               o_arrived;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic        [1:0]  i_cfg_index;
    logic        [31:0] i_cfg_data;
    int                 pending;
    int                 failures;
    bit                 steady;
    bit                 hold_off_now;

    trapezoidal_motion_profile uut (.*);

    motion_profile_checker checker_i (.*, .o_pending(pending), .o_failures(failures));

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side: random stall bursts, one long hold-off on request, none at the end.
    initial begin
        int n;
        i_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off_now) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off_now = 0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 9);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                n = $urandom_range(0, 2) == 0 ? 30 : $urandom_range(1, 9);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Offer one request and hold it until it is taken.
    task automatic send_request(logic [31:0] s_pos, logic [31:0] g_pos, logic [31:0] t);
        if (!steady && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_position <= s_pos;
        i_target_position <= g_pos;
        i_elapsed_time <= t;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Register writes only once the block has drained.
    task automatic write_register(logic [1:0] idx, logic [31:0] data);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Random position: full range, or near zero, or near an extreme.
    function automatic logic [31:0] pick_position();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return -($urandom >> $urandom_range(0, 31));
            default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 9999)
                                                 : 32'h8000_0000 + $urandom_range(0, 9999);
        endcase
    endfunction

    task automatic random_requests(int count);
        logic [31:0] s_pos;
        for (int k = 0; k < count; k++) begin
            s_pos = pick_position();
            send_request(s_pos, $urandom_range(0, 5) == 0 ? s_pos : pick_position(),
                         $urandom >> $urandom_range(0, 31));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_start_position = '0;
        i_target_position = '0;
        i_elapsed_time = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MAX_VELOCITY;
        i_cfg_data = '0;
        steady = 0;
        hold_off_now = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: range extremes, zero distance, time extremes at reset settings.
        send_request(32'h8000_0000, 32'h7fff_ffff, 32'd0);
        send_request(32'h8000_0000, 32'h7fff_ffff, 32'h0100_0000);
        send_request(32'h7fff_ffff, 32'h8000_0000, 32'h0100_0000);
        send_request(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        send_request(32'd1000, 32'd1000, 32'd0);
        send_request(32'd1000, 32'd1000, 32'd1);
        send_request(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
        send_request(32'd0, 32'h0001_0000, 32'h0001_0000);
        send_request(32'd0, 32'h0001_0000, 32'h0001_8000);
        send_request(32'd0, 32'h0010_0000, 32'h0002_0000);
        send_request(32'd0, 32'h0010_0000, 32'h000a_0000);
        send_request(32'd0, 32'h0010_0000, 32'h0010_8000);
        send_request(32'h0010_0000, 32'd0, 32'h000f_0000);
        send_request(32'd0, 32'd1, 32'd5);
        random_requests(300);

        // Extremes of both registers.
        write_register(CFG_MAX_VELOCITY, 32'h7fff_ffff);
        write_register(CFG_ACCELERATION, 32'h7fff_ffff);
        hold_off_now = 1;
        random_requests(350);

        // Zero registers count as one LSB; the top bit is dropped.
        write_register(CFG_MAX_VELOCITY, 32'h8000_0000);
        write_register(CFG_ACCELERATION, 32'hffff_ffff);
        write_register(CFG_SPARE, $urandom);
        random_requests(300);

        write_register(CFG_ACCELERATION, 32'h0000_0000);
        write_register(CFG_MAX_VELOCITY, 32'h0040_0000);
        random_requests(300);

        for (int r = 0; r < 3; r++) begin
            write_register(CFG_MAX_VELOCITY, $urandom >> $urandom_range(1, 24));
            write_register(CFG_ACCELERATION, $urandom >> $urandom_range(1, 24));
            random_requests(200);
        end
        steady = 1;
        random_requests(150);
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("trapezoidal_motion_profile: match");
        end else begin
            $display("trapezoidal_motion_profile: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("trapezoidal_motion_profile: mismatch");
        $finish;
    end
endmodule
